[hdl/gdr_pkg.sv]
// gdr_pkg: widths, grid constants and the queue entry type of the grid disc reveal map.
// Used by gdr_front, gdr_back, gdr_result_q and grid_disc_reveal_map; depends on nothing.
`default_nettype none

package gdr_pkg;

    // Grid shape; the column count must be a power of two (row/column split is a bit split).
    localparam int unsigned GRID_COLS  = 128;
    localparam int unsigned GRID_ROWS  = 128;
    localparam int unsigned CELL_TOTAL = GRID_COLS * GRID_ROWS;
    localparam int unsigned COL_BITS   = $clog2(GRID_COLS);
    localparam int unsigned ADDR_W     = $clog2(CELL_TOTAL);

    localparam int unsigned IDX_W  = 14;
    localparam int unsigned RQ_W   = 8;
    localparam int unsigned FRAC_W = 4;
    localparam int unsigned SPAN_W = RQ_W - FRAC_W;
    localparam int unsigned OFF_W  = SPAN_W + 1;
    localparam int unsigned LIM_W  = 2 * RQ_W;
    localparam int unsigned SQ_W   = 2 * SPAN_W;
    localparam int unsigned SUM_W  = SQ_W + 1;
    localparam int unsigned D2_W   = SUM_W + 2 * FRAC_W;
    localparam int unsigned ROW_W  = IDX_W - COL_BITS;
    localparam int unsigned MARK_W = IDX_W + 1;

    localparam int unsigned ROWS_CMP_W = $clog2(GRID_ROWS) + 1;
    localparam int unsigned X_BASE_W   = (COL_BITS > OFF_W) ? COL_BITS : OFF_W;
    localparam int unsigned X_W        = X_BASE_W + 2;
    localparam int unsigned Z_BASE_A   = (ROW_W > OFF_W) ? ROW_W : OFF_W;
    localparam int unsigned Z_BASE_W   = (Z_BASE_A > ROWS_CMP_W) ? Z_BASE_A : ROWS_CMP_W;
    localparam int unsigned Z_W        = Z_BASE_W + 2;

    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int unsigned RESQ_DEPTH = 2;
    localparam int unsigned RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int unsigned RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef enum logic {
        ACT_REVEAL = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef struct packed {
        action_t                 action;
        logic [IDX_W-1:0]        idx;
        logic [COL_BITS-1:0]     col;
        logic [ROW_W-1:0]        row;
        logic [SPAN_W-1:0]       span;
        logic [OFF_W-1:0]        span2;
        logic [LIM_W-1:0]        lim;
        logic                    in_range;
        logic                    m1_ok;
        logic                    m2_ok;
    } cmd_t;

endpackage

`default_nettype wire

[hdl/gdr_front.sv]
// gdr_front: accepts items, splits index into column and row, squares the radius,
// and holds classified commands in a short queue for the back end. Depends on gdr_pkg.
`default_nettype none

module gdr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         action,
    input  wire logic [gdr_pkg::IDX_W-1:0]    cell_index,
    input  wire logic [gdr_pkg::RQ_W-1:0]     radius_q4,
    input  wire logic                         clearing,
    output logic                              cmd_valid,
    output gdr_pkg::cmd_t                     cmd,
    input  wire logic                         cmd_take
);

    localparam int unsigned DEPTH = gdr_pkg::CMDQ_DEPTH;
    localparam int unsigned PW    = gdr_pkg::CMDQ_PTR_W;
    localparam int unsigned CW    = gdr_pkg::CMDQ_CNT_W;
    localparam int unsigned LW    = gdr_pkg::LIM_W;
    localparam int unsigned MW    = gdr_pkg::MARK_W;
    localparam int unsigned FW    = gdr_pkg::FRAC_W;
    localparam int unsigned IW    = gdr_pkg::IDX_W;
    localparam int unsigned CB    = gdr_pkg::COL_BITS;

    gdr_pkg::cmd_t   q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    gdr_pkg::cmd_t   new_cmd;
    logic            do_push;
    logic            do_pop;
    logic [MW-1:0]   m1_idx;
    logic [MW-1:0]   m2_idx;

    always_comb
    begin
        m1_idx = MW'(cell_index) + MW'(1);
        m2_idx = MW'(cell_index) + MW'(gdr_pkg::GRID_COLS);

        new_cmd.action   = gdr_pkg::action_t'(action);
        new_cmd.idx      = cell_index;
        new_cmd.col      = cell_index[CB-1:0];
        new_cmd.row      = cell_index[IW-1:CB];
        new_cmd.span     = radius_q4[gdr_pkg::RQ_W-1:FW];
        new_cmd.span2    = {radius_q4[gdr_pkg::RQ_W-1:FW], 1'b0};
        new_cmd.lim      = LW'(radius_q4) * LW'(radius_q4);
        new_cmd.in_range = 32'(cell_index) < gdr_pkg::CELL_TOTAL;
        new_cmd.m1_ok    = 32'(m1_idx) < gdr_pkg::CELL_TOTAL;
        new_cmd.m2_ok    = 32'(m2_idx) < gdr_pkg::CELL_TOTAL;
    end

    assign full      = (cnt_reg == CW'(DEPTH)) || clearing;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/gdr_back.sv]
// gdr_back: clears the revealed map after reset, walks disc offsets one cell per cycle,
// sets the extra marks and serves reads from the map memory. Depends on gdr_pkg.
`default_nettype none

module gdr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire gdr_pkg::cmd_t cmd,
    output logic               cmd_take,
    input  wire logic          res_room,
    output logic               res_push,
    output logic               res_lit,
    output logic               clearing
);

    localparam int unsigned AW  = gdr_pkg::ADDR_W;
    localparam int unsigned XW  = gdr_pkg::X_W;
    localparam int unsigned ZW  = gdr_pkg::Z_W;
    localparam int unsigned OW  = gdr_pkg::OFF_W;
    localparam int unsigned SW  = gdr_pkg::SPAN_W;
    localparam int unsigned QW  = gdr_pkg::SQ_W;
    localparam int unsigned UW  = gdr_pkg::SUM_W;
    localparam int unsigned DW  = gdr_pkg::D2_W;
    localparam int unsigned MW  = gdr_pkg::MARK_W;
    localparam int unsigned CB  = gdr_pkg::COL_BITS;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_WALK  = 7'b0000100,
        ST_MARK0 = 7'b0001000,
        ST_MARK1 = 7'b0010000,
        ST_MARK2 = 7'b0100000,
        ST_READ  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    gdr_pkg::cmd_t       cur_reg, cur_next;
    logic [OW-1:0]       ox_reg, ox_next;
    logic [OW-1:0]       oz_reg, oz_next;

    logic                cell_mem [gdr_pkg::CELL_TOTAL];
    logic                rd_bit_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic [OW-1:0]       span_ext;
    logic [SW-1:0]       dx_abs;
    logic [SW-1:0]       dz_abs;
    logic [QW-1:0]       sq_x;
    logic [QW-1:0]       sq_z;
    logic [UW-1:0]       sq_sum;
    logic [DW-1:0]       d2;
    logic signed [XW-1:0] x_s;
    logic signed [ZW-1:0] z_s;
    logic                x_ok;
    logic                z_ok;
    logic                hit;
    logic [AW-1:0]       walk_addr;
    logic [MW-1:0]       m1_idx;
    logic [MW-1:0]       m2_idx;

    always_comb
    begin
        span_ext = OW'(cur_reg.span);
        dx_abs   = (ox_reg >= span_ext) ? SW'(ox_reg - span_ext) : SW'(span_ext - ox_reg);
        dz_abs   = (oz_reg >= span_ext) ? SW'(oz_reg - span_ext) : SW'(span_ext - oz_reg);
        sq_x     = QW'(dx_abs) * QW'(dx_abs);
        sq_z     = QW'(dz_abs) * QW'(dz_abs);
        sq_sum   = UW'(sq_x) + UW'(sq_z);
        d2       = DW'(sq_sum) << (2 * gdr_pkg::FRAC_W);

        x_s  = $signed(XW'(cur_reg.col)) + $signed(XW'(ox_reg)) - $signed(XW'(cur_reg.span));
        z_s  = $signed(ZW'(cur_reg.row)) + $signed(ZW'(oz_reg)) - $signed(ZW'(cur_reg.span));
        x_ok = !x_s[XW-1] && (x_s < $signed(XW'(gdr_pkg::GRID_COLS)));
        z_ok = !z_s[ZW-1] && (z_s < $signed(ZW'(gdr_pkg::GRID_ROWS)));
        hit  = x_ok && z_ok && (d2 <= DW'(cur_reg.lim));

        walk_addr = (AW'($unsigned(z_s)) << CB) | AW'($unsigned(x_s));
        m1_idx    = MW'(cur_reg.idx) + MW'(1);
        m2_idx    = MW'(cur_reg.idx) + MW'(gdr_pkg::GRID_COLS);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        ox_next      = ox_reg;
        oz_next      = oz_reg;
        cmd_take     = 1'b0;
        res_push     = 1'b0;
        res_lit      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = walk_addr;
        mem_wdata    = 1'b1;
        mem_re       = 1'b0;
        mem_raddr    = AW'(cmd.idx);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(gdr_pkg::CELL_TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_take = 1'b1;
                    cur_next = cmd;
                    ox_next  = '0;
                    oz_next  = '0;
                    if (cmd.action == gdr_pkg::ACT_READ)
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                mem_we = hit;
                if (oz_reg == cur_reg.span2)
                begin
                    oz_next = '0;
                    if (ox_reg == cur_reg.span2)
                    begin
                        state_next = ST_MARK0;
                    end
                    else
                    begin
                        ox_next = ox_reg + OW'(1);
                    end
                end
                else
                begin
                    oz_next = oz_reg + OW'(1);
                end
            end
            ST_MARK0:
            begin
                mem_we     = cur_reg.in_range;
                mem_waddr  = AW'(cur_reg.idx);
                state_next = ST_MARK1;
            end
            ST_MARK1:
            begin
                mem_we     = cur_reg.m1_ok;
                mem_waddr  = AW'(m1_idx);
                state_next = ST_MARK2;
            end
            ST_MARK2:
            begin
                mem_we     = cur_reg.m2_ok;
                mem_waddr  = AW'(m2_idx);
                res_push   = 1'b1;
                res_lit    = 1'b0;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                res_push   = 1'b1;
                res_lit    = cur_reg.in_range & rd_bit_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ox_reg  <= ox_next;
        oz_reg  <= oz_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_bit_reg <= cell_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/gdr_result_q.sv]
// gdr_result_q: short result queue that holds lit bits until the consumer pops them.
// Depends on gdr_pkg.
`default_nettype none

module gdr_result_q (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   res_push,
    input  wire logic   res_lit,
    output logic        res_room,
    output logic        empty,
    input  wire logic   pop,
    output logic        lit
);

    localparam int unsigned DEPTH = gdr_pkg::RESQ_DEPTH;
    localparam int unsigned PW    = gdr_pkg::RESQ_PTR_W;
    localparam int unsigned CW    = gdr_pkg::RESQ_CNT_W;

    logic            q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign res_room = (cnt_reg != CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign lit      = q_mem[rd_ptr_reg];
    assign do_push  = res_push && res_room;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= res_lit;
        end
    end

endmodule

`default_nettype wire

[hdl/grid_disc_reveal_map.sv]
// grid_disc_reveal_map: top level; front end, command queue, disc walker with map memory,
// and result queue. Depends on gdr_pkg, gdr_front, gdr_back and gdr_result_q.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | push / full        | action, cell_index, radius_q4
//   result   | pop / empty        | lit
//
// Reveal: dispatch, then a walk over (2*floor(r)+1)^2 disc offsets, then ST_MARK0..ST_MARK2;
// walk and marks use the single map write port. Read: dispatch, then a registered read.
// After reset the map is cleared one cell per cycle over all 16384 cells; full stays high meanwhile.
// Two commands queue ahead of the walker; results wait in a two-entry queue, and the
// walker starts a new command only while that queue has room.
`default_nettype none

module grid_disc_reveal_map (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         action,
    input  wire logic [gdr_pkg::IDX_W-1:0]    cell_index,
    input  wire logic [gdr_pkg::RQ_W-1:0]     radius_q4,
    output logic                              empty,
    input  wire logic                         pop,
    output logic                              lit
);

    logic            clearing;
    logic            cmd_valid;
    gdr_pkg::cmd_t   cmd;
    logic            cmd_take;
    logic            res_room;
    logic            res_push;
    logic            res_lit;

    gdr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .cell_index (cell_index),
        .radius_q4  (radius_q4),
        .clearing   (clearing),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    gdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_room  (res_room),
        .res_push  (res_push),
        .res_lit   (res_lit),
        .clearing  (clearing)
    );

    gdr_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_lit  (res_lit),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .lit      (lit)
    );

endmodule

`default_nettype wire
